// ===== hw/rtl/swgs_pkg.sv =====
// ----------------------------------------------------------------------------
// swgs_pkg: shared types and constants for segment width and gap statistics
// holds the sequencer state type and the fixed datapath widths
// ----------------------------------------------------------------------------
package swgs_pkg;

  localparam int unsigned COORD_W    = 16;  // point coordinate width
  localparam int unsigned DIST_W     = 17;  // distance / ratio width
  localparam int unsigned SQ_W       = 34;  // squared distance, padded to pairs
  localparam int unsigned REM_W      = 18;  // root remainder width
  localparam int unsigned ALU_W      = 20;  // shared subtractor width
  localparam int unsigned ROOT_STEPS = 17;  // one result bit per step
  localparam int unsigned CNT_W      = 5;

  localparam logic [DIST_W-1:0] GAP_ALL_ONES = '1;
  localparam logic [DIST_W-1:0] RATIO_ONE    = DIST_W'(65536);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_GAP,
    ST_DIV,
    ST_OUT
  } swgs_state_e;

endpackage

// ===== hw/rtl/segment_width_gap_stats_core.sv =====
// ----------------------------------------------------------------------------
// segment_width_gap_stats_core: laser segment width and gap statistics
// iterative square root and divider on one shared subtractor
// ----------------------------------------------------------------------------
// usage
//   points of one segment enter on the input channel (in_valid_i / in_stall_o),
//   one signed mm point per transfer, last_point_i marks the segment end.
//   one result transfer leaves on the output channel (out_valid_o / out_stall_i)
//   for each segment; its fields are held in registers. extended_mode is written
//   via cfg_we_i / cfg_wdata_i by the user only while idle, unenforced by the block.
// sequence
//   the first point of a segment is only stored. every later point needs a
//   gap distance: the x and y squares, 17 root steps and a gap update. the
//   last point adds the width distance and, in extended mode with a nonzero
//   largest gap, a 17 step ratio divide. all root and divide steps go
//   through one 20 bit subtract/compare unit, and both squares through one
//   16x16 multiplier, so one point is in work at a time and in_stall_o stays
//   high until the block is idle again.
// reset and stall
//   reset clears the mode register, the point count and the gap trackers.
//   a result waits in its registers while out_stall_i is high; no new point
//   is taken until the result transfer completes, after which the segment
//   state is re-armed.
// ----------------------------------------------------------------------------
module segment_width_gap_stats_core
  import swgs_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  // point input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic                      last_point_i,
  // result output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [DIST_W-1:0]         width_o,
  output logic [DIST_W-1:0]         min_gap_o,
  output logic [DIST_W-1:0]         max_gap_o,
  output logic [DIST_W-1:0]         gap_ratio_o,
  output logic                      too_few_points_o
);

  swgs_state_e state_q, state_d;

  logic                      ext_mode_q;
  logic [1:0]                points_seen_q;
  logic [DIST_W-1:0]         least_q, greatest_q;
  logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic                      last_q;
  logic                      width_pass_q;   // 0: gap distance, 1: width distance

  logic [SQ_W-1:0]           acc_q;          // squared distance, shifted out by pairs
  logic [REM_W-1:0]          rem_q;          // root remainder or divide remainder
  logic [DIST_W-1:0]         root_q;         // root bits or quotient bits
  logic [CNT_W-1:0]          cnt_q;

  logic [DIST_W-1:0]         width_q, min_q, max_q, ratio_q;
  logic                      few_q;

  logic in_xfer, out_xfer, step_done;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign step_done   = (cnt_q == '0);

  // coordinate differences against previous or first point
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      adx, ady, mul_op;
  logic [2*COORD_W-1:0]    product;

  always_comb begin
    if (width_pass_q) begin
      dx = (COORD_W+1)'(x_q) - (COORD_W+1)'(first_x_q);
      dy = (COORD_W+1)'(y_q) - (COORD_W+1)'(first_y_q);
    end else begin
      dx = (COORD_W+1)'(x_q) - (COORD_W+1)'(prev_x_q);
      dy = (COORD_W+1)'(y_q) - (COORD_W+1)'(prev_y_q);
    end
  end

  assign adx     = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady     = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign mul_op  = (state_q == ST_SQ_X) ? adx : ady;
  assign product = mul_op * mul_op;

  // shared subtract/compare unit
  logic [ALU_W-1:0] alu_a, alu_b;
  logic [ALU_W:0]   alu_diff;
  logic             alu_ge;
  logic             div_bit;

  // only the top dividend bit below the skipped part is nonzero
  assign div_bit = (cnt_q == CNT_W'(ROOT_STEPS - 1)) ? least_q[0] : 1'b0;

  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a = {{(ALU_W-DIST_W-1){1'b0}}, rem_q[DIST_W-1:0], div_bit};
      alu_b = ALU_W'(greatest_q);
    end else begin
      alu_a = {rem_q, acc_q[SQ_W-1 -: 2]};
      alu_b = ALU_W'({root_q, 2'b01});
    end
  end

  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_ge   = !alu_diff[ALU_W];

  logic [DIST_W-1:0] root_next;
  assign root_next = {root_q[DIST_W-2:0], alu_ge};

  logic run_div;
  assign run_div = ext_mode_q && (greatest_q != '0);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (points_seen_q != 2'd0) begin
            state_d = ST_SQ_X;
          end else if (last_point_i) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_SQ_X: state_d = ST_SQ_Y;
      ST_SQ_Y: state_d = ST_ROOT;
      ST_ROOT: begin
        if (step_done) begin
          if (!width_pass_q) begin
            state_d = ST_GAP;
          end else if (run_div) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_GAP:  state_d = last_q ? ST_SQ_X : ST_IDLE;
      ST_DIV:  state_d = step_done ? ST_OUT : ST_DIV;
      ST_OUT:  state_d = out_xfer ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      ext_mode_q <= cfg_wdata_i;
    end
  end

  // segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_seen_q <= 2'd0;
      least_q       <= GAP_ALL_ONES;
      greatest_q    <= '0;
      first_x_q     <= '0;
      first_y_q     <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      width_pass_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          width_pass_q <= 1'b0;
          if (in_xfer && points_seen_q == 2'd0) begin
            first_x_q     <= point_x_i;
            first_y_q     <= point_y_i;
            prev_x_q      <= point_x_i;
            prev_y_q      <= point_y_i;
            points_seen_q <= 2'd1;
          end
        end
        ST_GAP: begin
          if (root_q < least_q) begin
            least_q <= root_q;
          end
          if (root_q > greatest_q) begin
            greatest_q <= root_q;
          end
          prev_x_q      <= x_q;
          prev_y_q      <= y_q;
          points_seen_q <= 2'd2;
          width_pass_q  <= 1'b1;
        end
        ST_OUT: begin
          // re-arm for the next segment
          if (out_xfer) begin
            points_seen_q <= 2'd0;
            least_q       <= GAP_ALL_ONES;
            greatest_q    <= '0;
            first_x_q     <= '0;
            first_y_q     <= '0;
            prev_x_q      <= '0;
            prev_y_q      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          x_q    <= point_x_i;
          y_q    <= point_y_i;
          last_q <= last_point_i;
          // single point segment result
          width_q <= '0;
          min_q   <= '0;
          max_q   <= '0;
          ratio_q <= '0;
          few_q   <= 1'b1;
        end
      end
      ST_SQ_X: acc_q <= SQ_W'(product);
      ST_SQ_Y: begin
        acc_q  <= acc_q + SQ_W'(product);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CNT_W'(ROOT_STEPS - 1);
      end
      ST_ROOT: begin
        acc_q <= {acc_q[SQ_W-3:0], 2'b00};
        if (step_done && width_pass_q) begin
          width_q <= root_next;
          min_q   <= ext_mode_q ? least_q : '0;
          max_q   <= ext_mode_q ? greatest_q : '0;
          ratio_q <= '0;
          few_q   <= 1'b0;
          // divide setup: dividend is least << 16, quotient fits 17 bits
          rem_q   <= REM_W'(least_q[DIST_W-1:1]);
          root_q  <= '0;
          cnt_q   <= CNT_W'(ROOT_STEPS - 1);
        end else begin
          rem_q  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
          root_q <= root_next;
          cnt_q  <= cnt_q - CNT_W'(1);
        end
      end
      ST_DIV: begin
        rem_q  <= alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
        root_q <= root_next;
        cnt_q  <= cnt_q - CNT_W'(1);
        if (step_done) begin
          ratio_q <= root_next;
        end
      end
      default: ;
    endcase
  end

  assign width_o          = width_q;
  assign min_gap_o        = min_q;
  assign max_gap_o        = max_q;
  assign gap_ratio_o      = ratio_q;
  assign too_few_points_o = few_q;

`ifndef NO_ASSERTIONS
  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_few_points_o |->
      width_o == '0 && min_gap_o == '0 && max_gap_o == '0 && gap_ratio_o == '0)
    else $error("single point result carries nonzero fields");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_gap_o <= max_gap_o)
    else $error("min gap above max gap");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gap_ratio_o <= RATIO_ONE)
    else $error("gap ratio above one");

  a_point_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o || points_seen_q != 2'd0)
    else $error("accepted point left no trace");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT || state_q == ST_DIV) |-> cnt_q < CNT_W'(ROOT_STEPS))
    else $error("step counter out of range");
`endif

endmodule

// ===== tb/segment_width_gap_stats_core_tb.sv =====
// ----------------------------------------------------------------------------
// segment_width_gap_stats_core_tb: self-checking bench for the segment core
// feeds laser segments point by point, predicts width and gap statistics
// per segment and checks every result transfer in order
// ----------------------------------------------------------------------------
module segment_width_gap_stats_core_tb;
  import swgs_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned SETTLE_CYCLES  = 96;      // worst point: gap + width + divide
  localparam int unsigned HOLDOFF_CYCLES = 600;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned RANDOM_POINTS  = 1300;
  localparam longint      TIMEOUT_CYCLES = 800_000;

  // coordinate corners used by the random generator
  localparam logic signed [COORD_W-1:0] EDGE_COORDS [5] = '{-32768, -1, 0, 1, 32767};

  // one result transfer, field order matches the port concatenation
  typedef struct packed {
    logic [DIST_W-1:0] width;
    logic [DIST_W-1:0] min_gap;
    logic [DIST_W-1:0] max_gap;
    logic [DIST_W-1:0] gap_ratio;
    logic              too_few;
  } seg_result_t;

  // --------------------------------------------------------------------------
  // segment statistics predictor and result checker
  // --------------------------------------------------------------------------
  class segment_scoreboard;
    bit                        ext_mode;
    logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
    int unsigned               points_seen;   // saturates at two
    logic [DIST_W-1:0]         least_gap, greatest_gap;
    seg_result_t               expected_q[$];
    int unsigned               mismatches, checked, single_point, extended, flat;

    function new();
      ext_mode = 1'b0;
      rearm();
    endfunction

    function void rearm();
      first_x      = '0;
      first_y      = '0;
      prev_x       = '0;
      prev_y       = '0;
      points_seen  = 0;
      least_gap    = GAP_ALL_ONES;
      greatest_gap = '0;
    endfunction

    // floor of the euclidean distance, built one root bit at a time
    function logic [DIST_W-1:0] point_distance(logic signed [COORD_W-1:0] ax, ay, bx, by);
      longint            dx, dy;
      longint unsigned   sq, cand;
      logic [DIST_W-1:0] root;
      dx   = longint'(ax) - longint'(bx);
      dy   = longint'(ay) - longint'(by);
      sq   = longint'(dx * dx + dy * dy);
      root = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
        cand = longint'(root | (DIST_W'(1) << b));
        if (cand * cand <= sq) root[b] = 1'b1;
      end
      return root;
    endfunction

    function void note_point(logic signed [COORD_W-1:0] x, y, bit last);
      seg_result_t            r;
      logic [DIST_W-1:0]      g;
      logic [DIST_W+15:0]     scaled;
      if (points_seen == 0) begin
        first_x = x;
        first_y = y;
      end else begin
        g = point_distance(x, y, prev_x, prev_y);
        if (g < least_gap)    least_gap    = g;
        if (g > greatest_gap) greatest_gap = g;
      end
      prev_x = x;
      prev_y = y;
      if (points_seen < 2) points_seen++;
      if (!last) return;

      r = '0;
      if (points_seen < 2) begin
        r.too_few = 1'b1;
        single_point++;
      end else begin
        r.width = point_distance(first_x, first_y, x, y);
        // mode is looked at only on the closing point
        if (ext_mode) begin
          extended++;
          r.min_gap = least_gap;
          r.max_gap = greatest_gap;
          if (greatest_gap != 0) begin
            scaled      = {least_gap, 16'h0} / greatest_gap;
            r.gap_ratio = scaled[DIST_W-1:0];
          end else begin
            flat++;
          end
        end
      end
      expected_q.push_back(r);
      rearm();
    endfunction

    function void report(string what, seg_result_t want, seg_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected width %0d min %0d max %0d ratio %0d few %0b,",
                 what, want.width, want.min_gap, want.max_gap, want.gap_ratio,
                 want.too_few);
        $display("  got width %0d min %0d max %0d ratio %0d few %0b",
                 got.width, got.min_gap, got.max_gap, got.gap_ratio, got.too_few);
      end
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t want;
      if (expected_q.size() == 0) begin
        report("result transfer with no segment pending", '0, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) report($sformatf("result %0d mismatch", checked), want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] point_x_i;
  logic signed [COORD_W-1:0] point_y_i;
  logic                      last_point_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [DIST_W-1:0]         width_o;
  logic [DIST_W-1:0]         min_gap_o;
  logic [DIST_W-1:0]         max_gap_o;
  logic [DIST_W-1:0]         gap_ratio_o;
  logic                      too_few_points_o;

  segment_width_gap_stats_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .point_x_i        (point_x_i),
    .point_y_i        (point_y_i),
    .last_point_i     (last_point_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .width_o          (width_o),
    .min_gap_o        (min_gap_o),
    .max_gap_o        (max_gap_o),
    .gap_ratio_o      (gap_ratio_o),
    .too_few_points_o (too_few_points_o)
  );

  segment_scoreboard sb = new();

  int unsigned               idle_pct;       // sender idle chance per cycle
  int unsigned               stall_pct;      // receiver stall chance per cycle
  bit                        holdoff_req;
  bit                        holdoff_on;
  int unsigned               points_sent;
  int unsigned               mode_writes;
  logic signed [COORD_W-1:0] last_x, last_y;

  // low phase first so the first rising edge lies one half period in
  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------

  // offer one point, with random idle cycles first, and hold it until taken
  task automatic send_point(logic signed [COORD_W-1:0] x, y, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(x, y, last);
    points_sent++;
    last_x = x;
    last_y = y;
  endtask

  // all results in, then let a non-closing point finish its gap work
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.ext_mode = m;
    mode_writes++;
  endtask

  // one segment of random length; points wander, jump, repeat or hit corners
  task automatic send_segment();
    int unsigned               len, pick;
    bit                        flat_seg;
    logic signed [COORD_W-1:0] x, y;
    pick = $urandom_range(99);
    if (pick < 10)      len = 1;
    else if (pick < 80) len = $urandom_range(6, 2);
    else                len = $urandom_range(20, 7);
    flat_seg = ($urandom_range(99) < 5);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (flat_seg || pick < 10) begin
        x = last_x;
        y = last_y;
      end else if (pick < 45) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else if (pick < 75) begin
        x = last_x + COORD_W'(int'($urandom_range(600)) - 300);
        y = last_y + COORD_W'(int'($urandom_range(600)) - 300);
      end else begin
        x = EDGE_COORDS[$urandom_range(4)];
        y = EDGE_COORDS[$urandom_range(4)];
      end
      send_point(x, y, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: check each result transfer, then pick the next stall value
  // --------------------------------------------------------------------------
  initial begin : result_sink
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result({width_o, min_gap_o, max_gap_o, gap_ratio_o, too_few_points_o});
      out_stall_i <= holdoff_on || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin : rx_holdoff
    holdoff_on = 1'b0;
    wait (holdoff_req);
    holdoff_on = 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
    holdoff_on = 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles, %0d results outstanding",
             TIMEOUT_CYCLES, sb.expected_q.size());
    $display("[segment_width_gap_stats_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_end;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= 1'b0;
    in_valid_i   <= 1'b0;
    point_x_i    <= '0;
    point_y_i    <= '0;
    last_point_i <= 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    holdoff_req  = 1'b0;
    points_sent  = 0;
    mode_writes  = 0;
    last_x       = '0;
    last_y       = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: basic mode first
    write_mode(1'b0);
    send_point(0, 0, 1'b1);                   // lone point
    send_point(-32768, -32768, 1'b0);         // widest diagonal
    send_point(32767, 32767, 1'b1);

    // directed: extended mode
    wait_idle();
    write_mode(1'b1);
    send_point(32767, -32768, 1'b0);
    send_point(-32768, 32767, 1'b1);          // ratio of exactly one
    send_point(5, 5, 1'b0);                   // all points on one spot
    send_point(5, 5, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(-32768, 32767, 1'b1);          // lone point, extended
    send_point(0, 0, 1'b0);
    send_point(3, 4, 1'b0);
    send_point(3, 4, 1'b0);                   // zero gap in a moving segment
    send_point(-32768, 0, 1'b0);
    send_point(100, 100, 1'b1);

    // directed: mode flips while a segment is open
    send_point(10, 10, 1'b0);
    send_point(20, 20, 1'b0);
    wait_idle();
    write_mode(1'b0);
    send_point(30, 35, 1'b1);
    send_point(-7, 9, 1'b0);
    send_point(400, -300, 1'b0);
    wait_idle();
    write_mode(1'b1);
    send_point(-1000, 2000, 1'b1);

    // random segments; idling profile cycles, mode changes per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 4) write_mode(p % 2 == 0);
      else       write_mode(1'($urandom_range(1)));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      if (p == 0) holdoff_req = 1'b1;
      phase_end = points_sent + RANDOM_POINTS / NUM_PHASES;
      while (points_sent < phase_end) send_segment();
    end

    // drain and latency tail
    wait_idle();
    if (sb.expected_q.size() != 0) sb.mismatches++;

    $display("checked %0d segment results from %0d points: %0d single-point, %0d extended",
             sb.checked, points_sent, sb.single_point, sb.extended);
    $display("%0d extended segments had all points coinciding, mode written %0d times",
             sb.flat, mode_writes);
    if (sb.mismatches == 0) begin
      $display("[segment_width_gap_stats_core] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[segment_width_gap_stats_core] ERROR");
    end
    $finish;
  end

endmodule
